### rtl/core/tvna_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle vertex/normal assembler package
// Shared item types, store entry layout, operation and status codes, and the
// sequencer states of the core.
// ----------------------------------------------------------------------------
package tvna_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_LOAD_VERTEX = 2'd0;
    localparam logic [1:0] OP_LOAD_NORMAL = 2'd1;
    localparam logic [1:0] OP_FACE        = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX  = 2'd1;
    localparam logic [1:0] ST_DEGENERATE = 2'd2;

    // Three Q8.16 components, x in element 0.
    typedef logic [2:0][23:0] t_vec3;

    // One store entry with its loaded flag.
    typedef struct packed {
        logic  loaded;
        t_vec3 c;
    } t_entry;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         slot;
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [23:0] coord_z;
        logic [10:0]        first_corner;
        logic [10:0]        second_corner;
        logic [10:0]        third_corner;
        logic [10:0]        first_normal;
        logic [10:0]        second_normal;
        logic [10:0]        third_normal;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [23:0] norm_x;
        logic signed [23:0] norm_y;
        logic signed [23:0] norm_z;
        logic               last_corner;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EDGE,
        S_CROSS,
        S_ABS,
        S_NORM,
        S_SQ,
        S_SQRT,
        S_DIV,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

### rtl/core/triangle_vertex_normal_assembler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle vertex/normal assembler core
// Loads vertices and normals into two stores and, for each face item, sends
// three corner results carrying a status and, for good indices, position and
// either the stored normal or the unit face normal computed with one shared
// 32x32 multiplier and bit-serial square root and division.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+-----------------------
//   input    | start high, busy low    | i_item  (t_in_item)
//   result   | o_strobe, one cycle     | o_result (t_out_item)
//
// Load items never raise busy. A face item with good vertex indices keeps busy
// high through the store reads, the edges, the cross product on the multiplier,
// the magnitudes, the normalizing steps, the squared length, the square root
// steps, the division steps (one run per component) and the result cycles of
// the three corners. A face with a bad vertex index goes from the store reads
// straight to the result cycles, and a degenerate face from the magnitudes.
// Each result is registered and leaves in the cycle after its result cycle.
// After reset a clearing pass over max(VERTEX_DEPTH, NORMAL_DEPTH) entries
// clears the loaded flags; busy is high meanwhile. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module triangle_vertex_normal_assembler_core #(
    parameter int VERTEX_DEPTH = 1024,
    parameter int NORMAL_DEPTH = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire tvna_pkg::t_in_item   i_item,
    output logic                      busy,
    output logic                      o_strobe,
    output tvna_pkg::t_out_item       o_result
);
    import tvna_pkg::*;

    localparam int VAW       = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int NAW       = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
    localparam int CLR_DEPTH = (VERTEX_DEPTH > NORMAL_DEPTH) ? VERTEX_DEPTH : NORMAL_DEPTH;
    localparam int CW        = $clog2(CLR_DEPTH + 1);
    localparam int EW        = $bits(t_entry);

    t_state r_state, n_state;
    logic [CW-1:0] r_clr;
    logic [4:0]    r_cnt;
    logic [1:0]    r_ci;

    logic [2:0][10:0] r_vi, r_ni;
    t_vec3            r_p [3];
    t_vec3            r_nrm [3];
    logic [2:0]       r_vok, r_nok;
    logic             r_bad, r_degen;

    logic signed [24:0] r_e1 [3];
    logic signed [24:0] r_e2 [3];
    logic signed [50:0] r_c [3];
    logic [50:0]        r_a [3];
    logic [2:0]         r_neg;
    logic signed [63:0] r_prod;
    logic [61:0]        r_len2;
    logic [61:0]        r_x, r_res, r_bit;
    logic [30:0]        r_root;
    logic [32:0]        r_rem;
    logic [16:0]        r_num;
    logic [15:0]        r_q;
    logic [23:0]        r_fn [3];

    logic               n_strobe;
    t_out_item          n_result;

    // ------------------------------------------------------------------
    // Stores.
    // ------------------------------------------------------------------
    logic           accept, vwe, nwe;
    logic [VAW-1:0] vwaddr, vraddr;
    logic [NAW-1:0] nwaddr, nraddr;
    t_entry         wentry, vrd, nrd;
    logic [EW-1:0]  vrd_bits, nrd_bits;
    logic [10:0]    rd_vidx, rd_nidx;

    assign accept = start && !busy;

    always_comb begin
        wentry.loaded = 1'b1;
        wentry.c      = {i_item.coord_z, i_item.coord_y, i_item.coord_x};
        vwe    = 1'b0;
        nwe    = 1'b0;
        vwaddr = VAW'(i_item.slot);
        nwaddr = NAW'(i_item.slot);
        if (r_state == S_CLEAR) begin
            wentry = '0;
            vwe    = ({1'b0, r_clr} < (CW + 1)'(VERTEX_DEPTH));
            nwe    = ({1'b0, r_clr} < (CW + 1)'(NORMAL_DEPTH));
            vwaddr = VAW'(r_clr);
            nwaddr = NAW'(r_clr);
        end else if (accept) begin
            vwe = (i_item.opcode == OP_LOAD_VERTEX) &&
                  ({7'd0, i_item.slot} < 17'(VERTEX_DEPTH));
            nwe = (i_item.opcode == OP_LOAD_NORMAL) &&
                  ({7'd0, i_item.slot} < 17'(NORMAL_DEPTH));
        end
    end

    // Read address of the corner being fetched.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin rd_vidx = r_vi[0]; rd_nidx = r_ni[0]; end
            2'd1:    begin rd_vidx = r_vi[1]; rd_nidx = r_ni[1]; end
            default: begin rd_vidx = r_vi[2]; rd_nidx = r_ni[2]; end
        endcase
        vraddr = VAW'({6'd0, rd_vidx} - 17'd1);
        nraddr = NAW'({6'd0, rd_nidx} - 17'd1);
    end

    tvna_store #(.DEPTH(VERTEX_DEPTH), .WIDTH(EW)) u_vertex_store (
        .i_clk   (i_clk),
        .i_we    (vwe),
        .i_waddr (vwaddr),
        .i_wdata (wentry),
        .i_raddr (vraddr),
        .o_rdata (vrd_bits)
    );

    tvna_store #(.DEPTH(NORMAL_DEPTH), .WIDTH(EW)) u_normal_store (
        .i_clk   (i_clk),
        .i_we    (nwe),
        .i_waddr (nwaddr),
        .i_wdata (wentry),
        .i_raddr (nraddr),
        .o_rdata (nrd_bits)
    );

    assign vrd = vrd_bits;
    assign nrd = nrd_bits;

    // Index range checks for the corner captured this cycle.
    logic [1:0]  cap_k;
    logic [10:0] cap_vidx, cap_nidx;
    logic        cap_vok, cap_nok;
    logic        all_vok;

    always_comb begin
        cap_k = r_cnt[1:0] - 2'd1;
        case (cap_k)
            2'd0:    begin cap_vidx = r_vi[0]; cap_nidx = r_ni[0]; end
            2'd1:    begin cap_vidx = r_vi[1]; cap_nidx = r_ni[1]; end
            default: begin cap_vidx = r_vi[2]; cap_nidx = r_ni[2]; end
        endcase
        cap_vok = (cap_vidx != 11'd0) && ({6'd0, cap_vidx} <= 17'(VERTEX_DEPTH)) &&
                  vrd.loaded;
        cap_nok = (cap_nidx != 11'd0) && ({6'd0, cap_nidx} <= 17'(NORMAL_DEPTH)) &&
                  nrd.loaded;
        // On the last read cycle the third corner is checked together with the
        // two flags already captured.
        all_vok = cap_vok && r_vok[1] && r_vok[0];
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand selection.
    // ------------------------------------------------------------------
    logic signed [24:0] ma, mb;
    logic signed [31:0] mul_a, mul_b;
    logic [1:0]         sq_k;
    logic [1:0]         cr_k;

    always_comb begin
        ma = r_e1[0];
        mb = r_e2[0];
        case (r_cnt[2:0])
            3'd0:    begin ma = r_e1[1]; mb = r_e2[2]; end
            3'd1:    begin ma = r_e1[2]; mb = r_e2[1]; end
            3'd2:    begin ma = r_e1[2]; mb = r_e2[0]; end
            3'd3:    begin ma = r_e1[0]; mb = r_e2[2]; end
            3'd4:    begin ma = r_e1[0]; mb = r_e2[1]; end
            3'd5:    begin ma = r_e1[1]; mb = r_e2[0]; end
            default: begin ma = r_e1[0]; mb = r_e2[0]; end
        endcase
        sq_k = (r_cnt[1:0] == 2'd3) ? 2'd2 : r_cnt[1:0];
        cr_k = 2'((r_cnt - 5'd1) >> 1);
        if (r_state == S_SQ) begin
            mul_a = signed'({2'b00, r_a[sq_k][29:0]});
            mul_b = signed'({2'b00, r_a[sq_k][29:0]});
        end else begin
            mul_a = 32'(ma);
            mul_b = 32'(mb);
        end
    end

    // ------------------------------------------------------------------
    // Normalizing, square root and division step logic.
    // ------------------------------------------------------------------
    logic        hi38, hi30, hi29, hi21, c_zero;
    logic [62:0] sq_sum;
    logic        sq_ge;
    logic [46:0] div_num;
    logic [32:0] div_t;
    logic        div_ge;
    logic [16:0] div_q;
    logic [1:0]  sel_k;

    always_comb begin
        hi38   = |{r_a[0][50:38], r_a[1][50:38], r_a[2][50:38]};
        hi30   = |{r_a[0][50:30], r_a[1][50:30], r_a[2][50:30]};
        hi29   = |{r_a[0][50:29], r_a[1][50:29], r_a[2][50:29]};
        hi21   = |{r_a[0][50:21], r_a[1][50:21], r_a[2][50:21]};
        c_zero = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
        sq_sum = {1'b0, r_res} + {1'b0, r_bit};
        sq_ge  = {1'b0, r_x} >= sq_sum;
        sel_k  = (r_ci == 2'd3) ? 2'd2 : r_ci;
        div_num = {1'b0, r_a[sel_k][29:0], 16'd0} + 47'(r_root[30:1]);
        div_t   = {r_rem[31:0], r_num[16]};
        div_ge  = div_t >= {2'b00, r_root};
        div_q   = {r_q, div_ge};
    end

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == CW'(CLR_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (accept && i_item.opcode == OP_FACE) n_state = S_READ;
            S_READ: begin
                if (r_cnt == 5'd3) begin
                    n_state = all_vok ? S_EDGE : S_EMIT;
                end
            end
            S_EDGE:  n_state = S_CROSS;
            S_CROSS: if (r_cnt == 5'd6) n_state = S_ABS;
            S_ABS:   n_state = c_zero ? S_EMIT : S_NORM;
            S_NORM:  if (!hi30 && hi29) n_state = S_SQ;
            S_SQ:    if (r_cnt == 5'd3) n_state = S_SQRT;
            S_SQRT:  if (r_cnt == 5'd30) n_state = S_DIV;
            S_DIV:   if (r_cnt == 5'd17 && r_ci == 2'd2) n_state = S_EMIT;
            S_EMIT:  if (r_cnt == 5'd2) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Result outputs.
    // ------------------------------------------------------------------
    logic [1:0]  ek;
    logic [10:0] e_nidx;

    always_comb begin
        ek       = (r_cnt[1:0] == 2'd3) ? 2'd2 : r_cnt[1:0];
        e_nidx   = r_ni[ek];
        n_strobe = 1'b0;
        n_result = '0;
        unique case (r_state)
            S_EMIT: begin
                n_strobe             = 1'b1;
                n_result.last_corner = (ek == 2'd2);
                if (r_bad) begin
                    n_result.status = ST_BAD_INDEX;
                end else begin
                    n_result.pos_x = r_p[ek][0];
                    n_result.pos_y = r_p[ek][1];
                    n_result.pos_z = r_p[ek][2];
                    if (e_nidx == 11'd0) begin
                        if (r_degen) begin
                            n_result.status = ST_DEGENERATE;
                        end else begin
                            n_result.norm_x = r_fn[0];
                            n_result.norm_y = r_fn[1];
                            n_result.norm_z = r_fn[2];
                            n_result.status = ST_OK;
                        end
                    end else if (!r_nok[ek]) begin
                        n_result.status = ST_BAD_INDEX;
                    end else begin
                        n_result.norm_x = r_nrm[ek][0];
                        n_result.norm_y = r_nrm[ek][1];
                        n_result.norm_z = r_nrm[ek][2];
                        n_result.status = ST_OK;
                    end
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_ci     <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= n_strobe;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + CW'(1);
            end
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (r_state != S_DIV) begin
                r_ci <= '0;
            end else if (r_cnt == 5'd17) begin
                r_ci  <= r_ci + 2'd1;
                r_cnt <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        o_result <= n_result;
        r_prod   <= mul_a * mul_b;

        unique case (r_state)
            S_IDLE: begin
                r_vi <= {i_item.third_corner, i_item.second_corner, i_item.first_corner};
                r_ni <= {i_item.third_normal, i_item.second_normal, i_item.first_normal};
                r_degen <= 1'b0;
            end
            S_READ: begin
                if (r_cnt != 5'd0) begin
                    r_p[cap_k]   <= vrd.c;
                    r_nrm[cap_k] <= nrd.c;
                    r_vok[cap_k] <= cap_vok;
                    r_nok[cap_k] <= cap_nok;
                end
                r_bad <= 1'b0;
                if (r_cnt == 5'd3) begin
                    r_bad <= !all_vok;
                end
            end
            S_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= {r_p[1][i][23], r_p[1][i]} - {r_p[0][i][23], r_p[0][i]};
                    r_e2[i] <= {r_p[2][i][23], r_p[2][i]} - {r_p[0][i][23], r_p[0][i]};
                end
            end
            S_CROSS: begin
                // The product of step n is registered and used in the next step.
                if (r_cnt != 5'd0) begin
                    if (r_cnt[0]) begin
                        r_c[cr_k] <= 51'(r_prod);
                    end else begin
                        r_c[cr_k] <= r_c[cr_k] - 51'(r_prod);
                    end
                end
            end
            S_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    r_a[i]   <= r_c[i][50] ? 51'(-r_c[i]) : r_c[i];
                    r_neg[i] <= r_c[i][50];
                end
                r_degen <= c_zero;
            end
            S_NORM: begin
                // Bring the largest magnitude into [2^29, 2^30).
                for (int i = 0; i < 3; i++) begin
                    if (hi38) begin
                        r_a[i] <= r_a[i] >> 8;
                    end else if (hi30) begin
                        r_a[i] <= r_a[i] >> 1;
                    end else if (!hi21) begin
                        r_a[i] <= r_a[i] << 8;
                    end else if (!hi29) begin
                        r_a[i] <= r_a[i] << 1;
                    end
                end
                r_len2 <= '0;
            end
            S_SQ: begin
                if (r_cnt != 5'd0) begin
                    r_len2 <= r_len2 + 62'(r_prod);
                end
                if (r_cnt == 5'd3) begin
                    r_x   <= r_len2 + 62'(r_prod);
                    r_res <= '0;
                    r_bit <= 62'd1 << 60;
                end
            end
            S_SQRT: begin
                // One root bit per cycle.
                if (sq_ge) begin
                    r_x   <= r_x - sq_sum[61:0];
                    r_res <= (r_res >> 1) + r_bit;
                    if (r_cnt == 5'd30) r_root <= 31'((r_res >> 1) + r_bit);
                end else begin
                    r_res <= r_res >> 1;
                    if (r_cnt == 5'd30) r_root <= 31'(r_res >> 1);
                end
                r_bit <= r_bit >> 2;
            end
            S_DIV: begin
                // One quotient bit per cycle; the quotient fits in 17 bits.
                if (r_cnt == 5'd0) begin
                    r_rem <= {3'd0, div_num[46:17]};
                    r_num <= div_num[16:0];
                    r_q   <= '0;
                end else begin
                    r_rem <= div_ge ? (div_t - {2'b00, r_root}) : div_t;
                    r_num <= r_num << 1;
                    r_q   <= div_q[15:0];
                    if (r_cnt == 5'd17) begin
                        r_fn[sel_k] <= r_neg[sel_k] ? 24'(-{7'd0, div_q}) : {7'd0, div_q};
                    end
                end
            end
            default: begin
                r_bad <= r_bad;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/tvna_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Store memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tvna_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 73,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### tb/sv/triangle_vertex_normal_assembler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle vertex/normal assembler core testbench
// Loads vertices and normals, sends face commands and checks every corner
// result against a local predictor of the stores and of the face normal.
// Random idle gaps on the command side; the run ends on a cycle limit too.
// ----------------------------------------------------------------------------
module triangle_vertex_normal_assembler_core_tb;
    import tvna_pkg::*;

    localparam int VDEPTH = 1024;
    localparam int NDEPTH = 1024;
    localparam int CYCLE_LIMIT = 400000;

    // Opcode with no operation behind it.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    triangle_vertex_normal_assembler_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // Predictor copy of the stores.
    t_vec3 vtx_mem  [VDEPTH];
    bit    vtx_valid[VDEPTH];
    t_vec3 nrm_mem  [NDEPTH];
    bit    nrm_valid[NDEPTH];

    t_in_item  cmd_queue[$];
    t_out_item corner_queue[$];
    int        error_count = 0;
    longint    cycle_count = 0;
    bit        hold_off = 0;
    bit        quiet_phase = 0;
    bit        stim_done = 0;

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Appends one command to the pending queue.
    task automatic add_cmd(input t_in_item it);
        cmd_queue = {cmd_queue, it};
    endtask

    // Unit face normal of three positions; returns 0 for a zero cross product.
    function automatic bit calc_face_normal(input t_vec3 p0, input t_vec3 p1,
                                            input t_vec3 p2, output t_vec3 nv);
        longint e1[3], e2[3], cr[3];
        longint unsigned mag[3], mx, len2, rt, q, rem, bitv;
        nv = '0;
        for (int i = 0; i < 3; i++) begin
            e1[i] = longint'($signed(p1[i])) - longint'($signed(p0[i]));
            e2[i] = longint'($signed(p2[i])) - longint'($signed(p0[i]));
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (cr[i] < 0) ? longint'(-cr[i]) : cr[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) return 0;
        while (mx >= 64'd1 << 30) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (mx < 64'd1 << 29) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        // Integer square root, digit by digit.
        rt = 0;
        rem = len2;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= rt + bitv) begin
                rem = rem - (rt + bitv);
                rt = (rt >> 1) + bitv;
            end else begin
                rt >>= 1;
            end
            bitv >>= 2;
        end
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 16) + (rt >> 1)) / rt;
            nv[i] = (cr[i] < 0) ? 24'(-longint'(q)) : 24'(q);
        end
        return 1;
    endfunction

    // Applies one accepted command to the predictor and queues its corners.
    task automatic predict_corners(input t_in_item it);
        logic [10:0] vi[3], ni[3];
        bit          ok, flat;
        t_vec3       fn, pos, nv;
        t_out_item   r;
        ok = 1;
        if (it.opcode == OP_LOAD_VERTEX) begin
            vtx_mem[it.slot] = {it.coord_z, it.coord_y, it.coord_x};
            vtx_valid[it.slot] = 1;
        end else if (it.opcode == OP_LOAD_NORMAL) begin
            nrm_mem[it.slot] = {it.coord_z, it.coord_y, it.coord_x};
            nrm_valid[it.slot] = 1;
        end else if (it.opcode == OP_FACE) begin
            vi = '{it.first_corner, it.second_corner, it.third_corner};
            ni = '{it.first_normal, it.second_normal, it.third_normal};
            for (int k = 0; k < 3; k++)
                if (vi[k] == 0 || vi[k] > VDEPTH || !vtx_valid[vi[k] - 1]) ok = 0;
            if (ok) flat = !calc_face_normal(vtx_mem[vi[0] - 1], vtx_mem[vi[1] - 1],
                                             vtx_mem[vi[2] - 1], fn);
            for (int k = 0; k < 3; k++) begin
                r = '0;
                r.last_corner = (k == 2);
                if (!ok) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    pos = vtx_mem[vi[k] - 1];
                    {r.pos_z, r.pos_y, r.pos_x} = pos;
                    nv = '0;
                    if (ni[k] == 0) begin
                        nv = fn;
                        r.status = flat ? ST_DEGENERATE : ST_OK;
                    end else if (ni[k] > NDEPTH || !nrm_valid[ni[k] - 1]) begin
                        r.status = ST_BAD_INDEX;
                    end else begin
                        nv = nrm_mem[ni[k] - 1];
                        r.status = ST_OK;
                    end
                    {r.norm_z, r.norm_y, r.norm_x} = nv;
                end
                corner_queue = {corner_queue, r};
            end
        end
    endtask

    // Driver: one command per transfer, random idle cycles except in a quiet phase.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_corners(i_item);
                void'(cmd_queue.pop_front());
            end
            if (start && busy) begin
                // Hold the pending command until it transfers.
            end else if (cmd_queue.size() > 0 && !hold_off &&
                         (quiet_phase || $urandom_range(99) >= 28)) begin
                start  <= 1'b1;
                i_item <= cmd_queue[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compares each strobed corner with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (corner_queue.size() == 0) begin
                $display("%0t: unexpected corner result %h", $time, o_result);
                error_count++;
            end else begin
                if (o_result !== corner_queue[0]) begin
                    $display("%0t: corner mismatch expected %h actual %h",
                             $time, corner_queue[0], o_result);
                    error_count++;
                end
                void'(corner_queue.pop_front());
            end
        end
    end

    function automatic t_in_item make_load(input logic [1:0] op, input int s,
                                           input int x, input int y, input int z);
        t_in_item it;
        it = '0;
        it.opcode = op;
        it.slot = 10'(s);
        it.coord_x = 24'(x);
        it.coord_y = 24'(y);
        it.coord_z = 24'(z);
        it.first_corner = 11'($urandom);
        it.second_corner = 11'($urandom);
        it.third_corner = 11'($urandom);
        it.first_normal = 11'($urandom);
        it.second_normal = 11'($urandom);
        it.third_normal = 11'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_face(input int a, input int b, input int c,
                                           input int na, input int nb, input int nc);
        t_in_item it;
        it = '0;
        it.opcode = OP_FACE;
        it.slot = 10'($urandom);
        it.coord_x = 24'($urandom);
        it.coord_y = 24'($urandom);
        it.coord_z = 24'($urandom);
        it.first_corner = 11'(a);
        it.second_corner = 11'(b);
        it.third_corner = 11'(c);
        it.first_normal = 11'(na);
        it.second_normal = 11'(nb);
        it.third_normal = 11'(nc);
        return it;
    endfunction

    // Index that usually names a loaded entry and sometimes a bad one.
    function automatic int pick_index(input int lo, input int hi, input bit allow_zero);
        int p;
        p = $urandom_range(99);
        if (p < 4) return allow_zero ? 0 : 2047;
        if (p < 7) return $urandom_range(2047, 1025);
        if (p < 9) return 1024;
        return $urandom_range(hi, lo);
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || start || corner_queue.size() > 0)
            @(posedge i_clk);
    endtask

    // Stimulus.
    initial begin
        int nv;
        int a, b, c;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, all operations, bad indices, degenerate faces.
        add_cmd(make_face(1, 2, 3, 0, 0, 0));
        add_cmd(make_load(OP_LOAD_VERTEX, 0, 0, 0, 0));
        add_cmd(make_load(OP_LOAD_VERTEX, 1, 8388607, 0, 0));
        add_cmd(make_load(OP_LOAD_VERTEX, 2, -8388608, 8388607, -8388608));
        add_cmd(make_load(OP_LOAD_VERTEX, 1023, 65536, 65536, 0));
        add_cmd(make_load(OP_LOAD_NORMAL, 0, 0, 0, 65536));
        add_cmd(make_load(OP_LOAD_NORMAL, 1023, -8388608, 8388607, -1));
        add_cmd(make_load(OP_RESERVED, 5, 1, 2, 3));
        add_cmd(make_face(1, 2, 3, 0, 0, 0));
        add_cmd(make_face(1, 2, 1024, 1, 1024, 0));
        add_cmd(make_face(1, 2, 3, 2, 1025, 2047));
        add_cmd(make_face(0, 2, 3, 0, 0, 0));
        add_cmd(make_face(1, 2047, 3, 0, 0, 0));
        add_cmd(make_face(1, 2, 5, 0, 0, 0));
        add_cmd(make_face(1, 1, 2, 0, 1, 0));
        add_cmd(make_face(1, 2, 2, 1024, 0, 0));
        add_cmd(make_load(OP_LOAD_VERTEX, 3, 131072, 262144, 393216));
        add_cmd(make_face(1, 2, 4, 0, 0, 0));
        add_cmd(make_face(2, 3, 1024, 0, 1, 0));
        wait_drained();

        // Sender pause once every expected corner has come.
        hold_off = 1;
        repeat (20) @(posedge i_clk);
        hold_off = 0;

        // Random part: short load bursts mixed with mostly well-formed faces.
        nv = 4;
        for (int n = 0; n < 230; n++) begin
            if (n == 80) quiet_phase = 1;
            if (n == 130) quiet_phase = 0;
            if ($urandom_range(99) < 30) begin
                a = (nv < 64) ? nv : $urandom_range(63);
                if (nv < 64) nv++;
                add_cmd(make_load($urandom_range(1) ? OP_LOAD_NORMAL : OP_LOAD_VERTEX,
                                  a, $urandom, $urandom, $urandom));
                if ($urandom_range(9) == 0)
                    add_cmd(make_load($urandom_range(1) ? OP_LOAD_NORMAL : OP_LOAD_VERTEX,
                                      $urandom_range(1023), $urandom,
                                      $urandom, $urandom));
            end else if ($urandom_range(99) < 3) begin
                add_cmd(make_load(OP_RESERVED, $urandom, $urandom,
                                  $urandom, $urandom));
            end else begin
                a = pick_index(1, nv, 1);
                b = pick_index(1, nv, 1);
                c = ($urandom_range(9) == 0) ? a : pick_index(1, nv, 1);
                add_cmd(make_face(a, b, c,
                    $urandom_range(1) ? 0 : pick_index(1, 64, 0),
                    $urandom_range(1) ? 0 : pick_index(1, 64, 0),
                    $urandom_range(1) ? 0 : pick_index(1, 64, 0)));
            end
            while (cmd_queue.size() > 4) @(posedge i_clk);
        end
        wait_drained();
        repeat (150) @(posedge i_clk);
        stim_done = 1;
    end

    // End of run.
    always @(posedge i_clk) begin
        if (stim_done) begin
            if (error_count == 0 && corner_queue.size() == 0) begin
                $display("== PASS ==");
            end else begin
                $display("== FAIL ==");
            end
            $finish;
        end else if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
